>>> design/avp_pkg.sv
// Shared types and constants for the average pooling unit.
package avp_pkg;

    // Configuration port widths and register fields
    localparam int CFG_INDEX_W = 2;
    localparam int FRAME_CFG_W = 11;
    localparam int POOL_CFG_W  = 4;
    localparam int CFG_DATA_W  = FRAME_CFG_W;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_POOL_HEIGHT  = 2'd2,
        CFG_POOL_WIDTH   = 2'd3
    } avp_cfg_idx_t;

    // Per-item control flags passed from front to back
    typedef struct packed {
        logic first;      // first sample of a window: start a new partial sum
        logic last;       // last sample of a window: divide and emit
        logic frame_end;  // window is the last one of the frame
    } avp_flags_t;

endpackage

>>> design/avp_fifo.sv
// Small register-based FIFO used between front and back and on the result side.
module avp_fifo
    import avp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = store_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

>>> design/avp_front.sv
// Front end: configuration registers, raster position tracking and item classification.
module avp_front
    import avp_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 1024,
    parameter int MAX_FRAME_HEIGHT = 1024,
    parameter int MAX_POOL         = 8,
    parameter int ADDR_W           = 10,
    parameter int AREA_W           = 7
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    output logic                   emit,
    output avp_flags_t             flags,
    output logic [ADDR_W-1:0]      addr,
    output logic [AREA_W-1:0]      area
);

    localparam int FW_W  = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int FH_W  = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int PC_W  = $clog2(MAX_POOL + 1);
    localparam int PW_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int WR_W  = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
    localparam int CB_W  = ADDR_W + PC_W + 1;
    localparam int RB_W  = WR_W + PC_W + 1;
    localparam int FW_RST = (28 > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : 28;
    localparam int FH_RST = (28 > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : 28;
    localparam int PL_RST = (2 > MAX_POOL) ? MAX_POOL : 2;

    // Clamped configuration
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [PC_W-1:0]   ph_reg;
    logic [PC_W-1:0]   pw_reg;

    // Raster position
    logic [PW_W-1:0]   ciw_reg, ciw_next;
    logic [ADDR_W-1:0] wc_reg, wc_next;
    logic [PW_W-1:0]   riw_reg, riw_next;
    logic [WR_W-1:0]   wr_reg, wr_next;

    logic [CB_W-1:0]   wbase, col;
    logic [RB_W-1:0]   rbase, row;
    logic              col_end, row_end, ciw_wrap, riw_wrap;
    logic              in_col, in_row, last_col, last_row;
    logic              col_at_last, row_at_last;
    logic [FRAME_CFG_W-1:0] frame_val;
    logic [POOL_CFG_W-1:0]  pool_val;
    logic [FW_W-1:0]   fw_clamp;
    logic [FH_W-1:0]   fh_clamp;
    logic [PC_W-1:0]   pool_clamp;

    // Clamp incoming register values
    always_comb
    begin
        frame_val = cfg_data[FRAME_CFG_W-1:0];
        pool_val  = cfg_data[POOL_CFG_W-1:0];
        if (frame_val == '0)
            fw_clamp = FW_W'(1);
        else if (frame_val > MAX_FRAME_WIDTH)
            fw_clamp = FW_W'(MAX_FRAME_WIDTH);
        else
            fw_clamp = FW_W'(frame_val);
        if (frame_val == '0)
            fh_clamp = FH_W'(1);
        else if (frame_val > MAX_FRAME_HEIGHT)
            fh_clamp = FH_W'(MAX_FRAME_HEIGHT);
        else
            fh_clamp = FH_W'(frame_val);
        if (pool_val == '0)
            pool_clamp = PC_W'(1);
        else if (pool_val > MAX_POOL)
            pool_clamp = PC_W'(MAX_POOL);
        else
            pool_clamp = PC_W'(pool_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_W'(FW_RST);
            fh_reg <= FH_W'(FH_RST);
            ph_reg <= PC_W'(PL_RST);
            pw_reg <= PC_W'(PL_RST);
        end
        else if (cfg_write)
        begin
            unique case (avp_cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  fw_reg <= fw_clamp;
                CFG_FRAME_HEIGHT: fh_reg <= fh_clamp;
                CFG_POOL_HEIGHT:  ph_reg <= pool_clamp;
                CFG_POOL_WIDTH:   pw_reg <= pool_clamp;
            endcase
        end
    end

    // Column geometry: window start, whole-window and last-window checks
    assign wbase    = CB_W'(wc_reg) * CB_W'(pw_reg);
    assign col      = wbase + CB_W'(ciw_reg);
    assign col_end  = (col + CB_W'(1)) >= CB_W'(fw_reg);
    assign ciw_wrap = (CB_W'(ciw_reg) + CB_W'(1)) >= CB_W'(pw_reg);
    assign in_col   = (wbase + CB_W'(pw_reg)) <= CB_W'(fw_reg);
    assign last_col = (wbase + CB_W'(pw_reg) + CB_W'(pw_reg)) > CB_W'(fw_reg);
    assign col_at_last = (CB_W'(ciw_reg) + CB_W'(1)) == CB_W'(pw_reg);

    // Row geometry
    assign rbase    = RB_W'(wr_reg) * RB_W'(ph_reg);
    assign row      = rbase + RB_W'(riw_reg);
    assign row_end  = (row + RB_W'(1)) >= RB_W'(fh_reg);
    assign riw_wrap = (RB_W'(riw_reg) + RB_W'(1)) >= RB_W'(ph_reg);
    assign in_row   = (rbase + RB_W'(ph_reg)) <= RB_W'(fh_reg);
    assign last_row = (rbase + RB_W'(ph_reg) + RB_W'(ph_reg)) > RB_W'(fh_reg);
    assign row_at_last = (RB_W'(riw_reg) + RB_W'(1)) == RB_W'(ph_reg);

    // Classification of the current item
    assign emit            = accept && in_col && in_row;
    assign flags.first     = (ciw_reg == '0) && (riw_reg == '0);
    assign flags.last      = col_at_last && row_at_last;
    assign flags.frame_end = last_col && last_row;
    assign addr            = wc_reg;
    assign area            = AREA_W'(ph_reg) * AREA_W'(pw_reg);

    // Raster position advance
    always_comb
    begin
        ciw_next = ciw_reg;
        wc_next  = wc_reg;
        riw_next = riw_reg;
        wr_next  = wr_reg;
        priority if (col_end)
        begin
            ciw_next = '0;
            wc_next  = '0;
            priority if (row_end)
            begin
                riw_next = '0;
                wr_next  = '0;
            end
            else if (riw_wrap)
            begin
                riw_next = '0;
                wr_next  = wr_reg + WR_W'(1);
            end
            else
            begin
                riw_next = riw_reg + PW_W'(1);
            end
        end
        else if (ciw_wrap)
        begin
            ciw_next = '0;
            wc_next  = wc_reg + ADDR_W'(1);
        end
        else
        begin
            ciw_next = ciw_reg + PW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ciw_reg <= '0;
            wc_reg  <= '0;
            riw_reg <= '0;
            wr_reg  <= '0;
        end
        else if (accept)
        begin
            ciw_reg <= ciw_next;
            wc_reg  <= wc_next;
            riw_reg <= riw_next;
            wr_reg  <= wr_next;
        end
    end

endmodule

>>> design/avp_back.sv
// Back end: per-column partial sums in memory and a bit-serial divide by window area.
module avp_back
    import avp_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 1024,
    parameter int SAMPLE_BITS     = 16,
    parameter int ADDR_W          = 10,
    parameter int AREA_W          = 7,
    parameter int SUM_W           = 22
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  avp_flags_t                    cmd_flags,
    input  logic [ADDR_W-1:0]             cmd_addr,
    input  logic [AREA_W-1:0]             cmd_area,
    input  logic signed [SAMPLE_BITS-1:0] cmd_sample,
    input  logic                          res_full,
    output logic                          res_push,
    output logic signed [SAMPLE_BITS-1:0] res_average,
    output logic                          res_frame_end
);

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    avp_flags_t               flags_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [AREA_W-1:0]        area_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SUM_W-1:0]  rdata_reg;
    logic                     neg_reg;
    logic [SUM_W-1:0]         dvd_reg;
    logic [AREA_W-1:0]        rem_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic signed [SUM_W-1:0]  col_sum_mem [MAX_FRAME_WIDTH];

    logic signed [SUM_W-1:0]  sample_ext;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         sum_mag;
    logic [AREA_W:0]          rem_sh;
    logic                     q_bit;
    logic [AREA_W:0]          rem_sub;
    logic [SUM_W-1:0]         avg_full;

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_OUT) && !res_full;

    // Running window sum for this column
    assign sample_ext = {{(SUM_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign sum        = flags_reg.first ? sample_ext : rdata_reg + sample_ext;
    assign sum_mag    = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

    // One restoring divide step
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, area_reg};
    assign rem_sub = rem_sh - {1'b0, area_reg};

    // Signed quotient, truncated toward zero
    assign avg_full      = neg_reg ? (~dvd_reg + SUM_W'(1)) : dvd_reg;
    assign res_average   = avg_full[SAMPLE_BITS-1:0];
    assign res_frame_end = flags_reg.frame_end;

    // Partial sum memory: read at dequeue, write back after accumulate
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            rdata_reg <= col_sum_mem[cmd_addr];
        end
        if (state_reg == ST_ACC)
        begin
            col_sum_mem[addr_reg] <= sum;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        flags_reg  <= cmd_flags;
                        addr_reg   <= cmd_addr;
                        area_reg   <= cmd_area;
                        sample_reg <= cmd_sample;
                        state_reg  <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (flags_reg.last)
                    begin
                        neg_reg   <= sum[SUM_W-1];
                        dvd_reg   <= sum_mag;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= q_bit ? rem_sub[AREA_W-1:0] : rem_sh[AREA_W-1:0];
                    dvd_reg <= {dvd_reg[SUM_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> design/average_pooling_2d_unit.sv
// Top level of the non-overlapping 2D average pooling unit.
// Samples enter in raster order, one per push; the front end tracks the raster
// position and forwards only samples that fall inside whole windows into a
// four-entry command queue; samples outside whole windows are not queued.
// The back end handles one queued sample at a time: a read-modify-write of the
// column partial sum in its single-port memory, and for the last sample of a
// window a bit-serial divide over the SUM_W-bit sum (22 bits at the default
// sizes), then a hand-off of the result to the two-entry result queue, where
// the back end waits while that queue is full. The partial sum memory needs
// no clearing: the first sample of each window overwrites its column entry.
module average_pooling_2d_unit
    import avp_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 1024,
    parameter int MAX_FRAME_HEIGHT = 1024,
    parameter int MAX_POOL         = 8,
    parameter int SAMPLE_BITS      = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          frame_end
);

    localparam int ADDR_W   = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
    localparam int AREA_W   = $clog2(MAX_POOL * MAX_POOL + 1);
    localparam int SUM_W    = SAMPLE_BITS + 2 * $clog2(MAX_POOL);
    localparam int FLAGS_W  = $bits(avp_flags_t);
    localparam int CMD_W    = FLAGS_W + ADDR_W + AREA_W + SAMPLE_BITS;
    localparam int RES_W    = SAMPLE_BITS + 1;
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    logic                          accept;
    logic                          cmd_push;
    avp_flags_t                    f_flags;
    logic [ADDR_W-1:0]             f_addr;
    logic [AREA_W-1:0]             f_area;
    logic [CMD_W-1:0]              cmd_in, cmd_out;
    logic                          cmd_full, cmd_empty, cmd_pop;
    avp_flags_t                    b_flags;
    logic [ADDR_W-1:0]             b_addr;
    logic [AREA_W-1:0]             b_area;
    logic signed [SAMPLE_BITS-1:0] b_sample;
    logic                          res_full, res_push;
    logic signed [SAMPLE_BITS-1:0] res_average;
    logic                          res_frame_end;
    logic [RES_W-1:0]              res_out;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    avp_front #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
        .MAX_POOL         (MAX_POOL),
        .ADDR_W           (ADDR_W),
        .AREA_W           (AREA_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .emit      (cmd_push),
        .flags     (f_flags),
        .addr      (f_addr),
        .area      (f_area)
    );

    // Command queue between front and back
    assign cmd_in = {f_flags, f_addr, f_area, sample};

    avp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .data_in  (cmd_in),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .data_out (cmd_out),
        .empty    (cmd_empty)
    );

    assign b_flags  = avp_flags_t'(cmd_out[CMD_W-1 -: FLAGS_W]);
    assign b_addr   = cmd_out[AREA_W + SAMPLE_BITS +: ADDR_W];
    assign b_area   = cmd_out[SAMPLE_BITS +: AREA_W];
    assign b_sample = cmd_out[SAMPLE_BITS-1:0];

    avp_back #(
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ADDR_W          (ADDR_W),
        .AREA_W          (AREA_W),
        .SUM_W           (SUM_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .cmd_flags     (b_flags),
        .cmd_addr      (b_addr),
        .cmd_area      (b_area),
        .cmd_sample    (b_sample),
        .res_full      (res_full),
        .res_push      (res_push),
        .res_average   (res_average),
        .res_frame_end (res_frame_end)
    );

    // Result queue toward the consumer
    avp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  ({res_average, res_frame_end}),
        .full     (res_full),
        .pop      (pop),
        .data_out (res_out),
        .empty    (empty)
    );

    assign average   = res_out[RES_W-1:1];
    assign frame_end = res_out[0];

    // Front only enqueues on an accepted item
    a_cmd_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (push && !full))
        else $error("command enqueued without an accepted item");

    // Back never dequeues from an empty command queue
    a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command dequeued while queue empty");

    // Back never pushes a result into a full result queue
    a_res_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed while result queue full");

    // A result push leaves the result queue non-empty on the next cycle
    a_res_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("pushed result not visible at output");

endmodule
